// File: src/edit_distance_engine_core_defines.svh
// Assertion macros for the edit distance core.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef EDIT_DISTANCE_ENGINE_CORE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EDE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edit distance core: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define EDE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edit distance core: next-cycle check failed");

`endif

// File: src/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and constants of the edit distance core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ede_pkg;

  localparam int MaxLen  = 32;
  localparam int CntW    = $clog2(MaxLen + 1);
  localparam int IdxW    = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int SymW    = 8;
  localparam int DistW   = 6;
  localparam int DistMax = (1 << DistW) - 1;

  typedef enum logic [1:0] {
    ActStart   = 2'd0,
    ActAppend  = 2'd1,
    ActProcess = 2'd2,
    ActFinish  = 2'd3
  } ede_action_e;

  typedef struct packed {
    ede_action_e           action;
    logic [SymW-1:0]       symbol;
  } ede_in_t;

  typedef struct packed {
    logic [DistW-1:0]      edit_distance;
    logic                  overflowed;
  } ede_out_t;

  // Wavefront data handed from one column cell to the next.
  typedef struct packed {
    logic                  vld;
    logic [SymW-1:0]       sym;
    logic [CntW-1:0]       new_cost;   // updated cost of the left column
    logic [CntW-1:0]       old_cost;   // cost of the left column before update
  } ede_link_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic                  clear;
    logic                  wr_en;
    logic [SymW-1:0]       wr_sym;
  } ede_cell_ctl_t;

endpackage

// File: src/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell
// One column of the edit distance row: holds a first-word character and its
// cost entry, updates it as a second-word character passes by.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ede_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ede_pkg::ede_cell_ctl_t    ctl_i,
  input  logic [ede_pkg::CntW-1:0]  col_i,
  input  ede_pkg::ede_link_t        link_i,
  output ede_pkg::ede_link_t        link_o,
  output logic [ede_pkg::CntW-1:0]  cost_o
);
  import ede_pkg::*;

  logic [SymW-1:0] ch_q;
  logic [CntW-1:0] cost_q, cost_d;
  logic            fresh_q;
  logic [CntW-1:0] cost_eff, min_lr, min_all;
  logic            out_vld_q;
  logic [SymW-1:0] out_sym_q;
  logic [CntW-1:0] out_new_q, out_old_q;

  // A fresh cell reads as its column index.
  assign cost_eff = fresh_q ? col_i : cost_q;
  assign cost_o   = cost_eff;

  always_comb begin
    min_lr  = (link_i.old_cost < link_i.new_cost) ? link_i.old_cost : link_i.new_cost;
    min_all = (min_lr < cost_eff) ? min_lr : cost_eff;
    if (ch_q == link_i.sym) begin
      cost_d = link_i.old_cost;
    end else begin
      cost_d = min_all + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      ch_q <= ctl_i.wr_sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      fresh_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= link_i.vld;
      if (link_i.vld) begin
        fresh_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.vld) begin
      cost_q    <= cost_d;
      out_sym_q <= link_i.sym;
      out_new_q <= cost_d;
      out_old_q <= cost_eff;
    end
  end

  assign link_o.vld      = out_vld_q;
  assign link_o.sym      = out_sym_q;
  assign link_o.new_cost = out_new_q;
  assign link_o.old_cost = out_old_q;

endmodule

// File: src/edit_distance_engine_core.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_core
// Levenshtein distance engine built as a systolic chain of column cells.
// ----------------------------------------------------------------------------
//   channel | signals                        | moves
//   --------+--------------------------------+-------------------------------
//   in      | in_valid_i, in_ready_o, in_i   | action and symbol, one item
//   out     | out_valid_o, out_ready_i, out_o| distance and overflow flag
//
// Start, append and process items never stall; process items may
// follow back to back, each sweeping the cell chain one column per cycle.
// A finish item waits until the wavefront has left the chain and for a
// free output reg.
// Reset is immediate: no clearing pass; cells read as their column index.
// Only a finish item stalls on out_ready_i.
`timescale 1ns / 1ps

module edit_distance_engine_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ede_pkg::ede_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ede_pkg::ede_out_t out_o
);
  import ede_pkg::*;
  `include "edit_distance_engine_core_defines.svh"

  logic                in_acc, start_acc, app_acc, proc_acc, fin_acc;
  logic                app_ok, proc_ok;
  logic [CntW-1:0]     first_len_q, first_len_d;
  logic [CntW-1:0]     sec_len_q, sec_len_d;
  logic                ovf_q, ovf_d;
  logic [CntW-1:0]     drain_q, drain_d;
  logic                head_vld_q;
  logic [SymW-1:0]     head_sym_q;
  logic [CntW-1:0]     head_new_q, head_old_q;
  logic                out_vld_q;
  ede_out_t            out_q, out_d;
  ede_link_t           link [MaxLen+1];
  logic [CntW-1:0]     cost [MaxLen];
  logic [MaxLen:0]     link_vld;
  logic [CntW-1:0]     sel_cost;
  logic [CntW-1:0]     last_idx;

  assign in_acc    = in_valid_i && in_ready_o;
  assign start_acc = in_acc && (in_i.action == ActStart);
  assign app_acc   = in_acc && (in_i.action == ActAppend);
  assign proc_acc  = in_acc && (in_i.action == ActProcess);
  assign fin_acc   = in_acc && (in_i.action == ActFinish);

  assign app_ok  = app_acc && (sec_len_q == '0) && (first_len_q < CntW'(MaxLen));
  assign proc_ok = proc_acc && (sec_len_q < CntW'(MaxLen));

  assign in_ready_o = (in_i.action != ActFinish) ||
                      ((drain_q == '0) && (!out_vld_q || out_ready_i));

  // Control state updates.
  always_comb begin
    first_len_d = first_len_q;
    sec_len_d   = sec_len_q;
    ovf_d       = ovf_q;
    drain_d     = (drain_q != '0) ? drain_q - CntW'(1) : drain_q;
    if (start_acc) begin
      first_len_d = '0;
      sec_len_d   = '0;
      ovf_d       = 1'b0;
      drain_d     = '0;
    end else if (app_acc && (sec_len_q == '0)) begin
      if (app_ok) begin
        first_len_d = first_len_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end else if (proc_acc) begin
      if (proc_ok) begin
        sec_len_d = sec_len_q + CntW'(1);
        drain_d   = CntW'(MaxLen);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q <= '0;
      sec_len_q   <= '0;
      ovf_q       <= 1'b0;
      drain_q     <= '0;
      head_vld_q  <= 1'b0;
    end else begin
      first_len_q <= first_len_d;
      sec_len_q   <= sec_len_d;
      ovf_q       <= ovf_d;
      drain_q     <= drain_d;
      head_vld_q  <= proc_ok;
    end
  end

  // Inject the column-zero costs alongside the symbol.
  always_ff @(posedge clk_i) begin
    if (proc_ok) begin
      head_sym_q <= in_i.symbol;
      head_new_q <= sec_len_q + CntW'(1);
      head_old_q <= sec_len_q;
    end
  end

  assign link[0].vld      = head_vld_q;
  assign link[0].sym      = head_sym_q;
  assign link[0].new_cost = head_new_q;
  assign link[0].old_cost = head_old_q;

  for (genvar k = 0; k < MaxLen; k++) begin : g_cell
    ede_cell_ctl_t ctl;

    assign ctl.clear  = start_acc;
    assign ctl.wr_en  = app_ok && (first_len_q == CntW'(k));
    assign ctl.wr_sym = in_i.symbol;

    ede_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .col_i  (CntW'(k + 1)),
      .link_i (link[k]),
      .link_o (link[k+1]),
      .cost_o (cost[k])
    );
  end

  for (genvar k = 0; k <= MaxLen; k++) begin : g_vld
    assign link_vld[k] = link[k].vld;
  end

  // Bottom-right entry of the row, saturated to the output width.
  assign last_idx = first_len_q - CntW'(1);

  always_comb begin
    if (first_len_q == '0) begin
      sel_cost = sec_len_q;
    end else begin
      sel_cost = cost[last_idx[IdxW-1:0]];
    end
    if (int'(sel_cost) > DistMax) begin
      out_d.edit_distance = DistW'(DistMax);
    end else begin
      out_d.edit_distance = DistW'(sel_cost);
    end
    out_d.overflowed = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_acc) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `EDE_ASSERT_IMP(a_len_bound, 1'b1, (first_len_q <= CntW'(MaxLen)) && (sec_len_q <= CntW'(MaxLen)))
  `EDE_ASSERT_IMP(a_chain_drained, drain_q == '0, link_vld[MaxLen-1:0] == '0)
  `EDE_ASSERT_NXT(a_finish_loads, fin_acc, out_valid_o && (out_o.overflowed == $past(ovf_q)))
  `EDE_ASSERT_IMP(a_out_from_finish, $rose(out_valid_o), $past(fin_acc))
  `EDE_ASSERT_NXT(a_late_append_dropped, app_acc && (sec_len_q != '0), $stable(first_len_q))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edit distance core. Word pairs with random
// content, small alphabets, overlong words and stray items are streamed in;
// a scoreboard tracks the cost row and checks every reported distance.
// ----------------------------------------------------------------------------

module tb_top;
  import ede_pkg::*;

  localparam int Limit  = 300000;
  localparam int NItems = 1040;

  // Tracks the cost row and queues the distance each finish item must report.
  class lev_scoreboard;
    logic [SymW-1:0] word_a [MaxLen];
    int unsigned     len_a;
    int unsigned     len_b;
    bit              ovf;
    int unsigned     row [MaxLen+1];
    ede_out_t        pending [$];
    int              errors;

    function void clear_state();
      len_a = 0;
      len_b = 0;
      ovf   = 1'b0;
      for (int i = 0; i <= MaxLen; i++) row[i] = i;
    endfunction

    function void note_item(ede_in_t it);
      int unsigned diag;
      int unsigned up;
      int unsigned best;
      int unsigned d;
      ede_out_t    res;
      case (it.action)
        ActStart: clear_state();
        ActAppend: begin
          // append is dropped once the second word has started
          if (len_b == 0) begin
            if (len_a >= MaxLen) begin
              ovf = 1'b1;
            end else begin
              word_a[len_a] = it.symbol;
              len_a++;
            end
          end
        end
        ActProcess: begin
          if (len_b >= MaxLen) begin
            ovf = 1'b1;
          end else begin
            diag = row[0];
            len_b++;
            row[0] = len_b;
            for (int i = 1; i <= len_a; i++) begin
              up = row[i];
              if (word_a[i-1] == it.symbol) begin
                row[i] = diag;
              end else begin
                best = (diag < up) ? diag : up;
                best = (row[i-1] < best) ? row[i-1] : best;
                row[i] = best + 1;
              end
              diag = up;
            end
          end
        end
        default: begin
          d = row[len_a];
          if (d > DistMax) d = DistMax;
          res.edit_distance = DistW'(d);
          res.overflowed    = ovf;
          pending.insert(pending.size(), res);
        end
      endcase
    endfunction

    function void check_result(ede_out_t got);
      ede_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb_top: result with nothing pending: dist %0d ovf %0b",
                   got.edit_distance, got.overflowed);
      end else begin
        want = pending.pop_front();
        if (got.edit_distance !== want.edit_distance ||
            got.overflowed !== want.overflowed) begin
          errors++;
          if (errors <= 10)
            $display("tb_top: mismatch: dist exp %0d got %0d, ovf exp %0b got %0b",
                     want.edit_distance, got.edit_distance,
                     want.overflowed, got.overflowed);
        end
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ede_in_t  in_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ede_out_t out_o;

  lev_scoreboard sb;
  int            sent;
  int            cycles;
  bit            steady;
  logic [7:0]    sym_pool [3];
  bit            wide_syms;

  edit_distance_engine_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_o);
  end

  task automatic push_item(input ede_action_e act, input logic [7:0] sym);
    ede_in_t it;
    it.action = act;
    it.symbol = sym;
    steady = (sent >= 500) && (sent < 650);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    sent++;
  endtask

  // Hold the input side until every pending distance has come out.
  task automatic drain();
    while (sb.pending.size() != 0) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic int pick_len();
    if ($urandom_range(99) < 8) return $urandom_range(MaxLen - 3, MaxLen + 4);
    return $urandom_range(10);
  endfunction

  function automatic logic [7:0] next_sym();
    if (wide_syms) return 8'($urandom_range(255));
    return sym_pool[$urandom_range(2)];
  endfunction

  task automatic run_session();
    int         n_a;
    int         n_b;
    logic [7:0] x;
    bit         extreme;
    extreme   = ($urandom_range(19) == 0);
    x         = 8'($urandom_range(255));
    wide_syms = ($urandom_range(3) == 0);
    foreach (sym_pool[k]) sym_pool[k] = 8'($urandom_range(255));
    n_a = extreme ? MaxLen + $urandom_range(2) : pick_len();
    n_b = extreme ? MaxLen + $urandom_range(2) : pick_len();
    push_item(ActStart, 8'($urandom_range(255)));
    repeat (n_a) push_item(ActAppend, extreme ? x : next_sym());
    for (int j = 0; j < n_b; j++) begin
      push_item(ActProcess, extreme ? ~x : next_sym());
      if ($urandom_range(19) == 0)
        push_item(ede_action_e'($urandom_range(3)), 8'($urandom_range(255)));
    end
    push_item(ActFinish, 8'($urandom_range(255)));
    if ($urandom_range(4) == 0) push_item(ActFinish, 8'($urandom_range(255)));
  endtask

  initial begin
    bit drained;
    sb = new;
    sb.clear_state();
    drained = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty words, repeated finish
    push_item(ActStart, 8'hFF);
    push_item(ActFinish, 8'h00);
    push_item(ActFinish, 8'hFF);
    // extreme symbols, empty second word, append after second word starts
    push_item(ActAppend, 8'h00);
    push_item(ActAppend, 8'hFF);
    push_item(ActFinish, 8'h00);
    push_item(ActProcess, 8'hFF);
    push_item(ActProcess, 8'h00);
    push_item(ActAppend, 8'h5A);
    push_item(ActFinish, 8'h00);
    // empty first word
    push_item(ActStart, 8'h00);
    push_item(ActProcess, 8'hAA);
    push_item(ActProcess, 8'h55);
    push_item(ActFinish, 8'hFF);
    // swapped pair
    push_item(ActStart, 8'h3C);
    push_item(ActAppend, 8'h80);
    push_item(ActAppend, 8'h01);
    push_item(ActProcess, 8'h01);
    push_item(ActProcess, 8'h80);
    push_item(ActFinish, 8'hC3);

    while (sent < NItems) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4))
          push_item(ede_action_e'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        run_session();
      end
      if ((sent >= 300 && !drained) || $urandom_range(29) == 0) begin
        drained = 1'b1;
        drain();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain();
    repeat (MaxLen + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
